// ===== src/login_stream_cipher_top_assert.svh =====
// Assertion macros for the login stream cipher checker.
`ifndef LOGIN_STREAM_CIPHER_TOP_ASSERT_SVH
`define LOGIN_STREAM_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define LSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("login stream cipher: same-cycle check failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define LSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("login stream cipher: next-cycle check failed");

`endif

// ===== src/lsc_pkg.sv =====
// Types, codes and constants shared by the login stream cipher modules.
package lsc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_INDEX_W = 3;

	// Request commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ENCRYPT = 1'b1;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_K1 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_K2 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_K3 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED_KEY = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CIPHER_MODE = 3'd4;

	// Cipher modes; the unused code falls back to the current scheme
	localparam logic [1:0] MODE_CURRENT = 2'd0;
	localparam logic [1:0] MODE_OLD = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;

	// Seed masks
	localparam logic [15:0] SEED_MASK_LOW = 16'haaaa;
	localparam logic [15:0] SEED_MASK_HIGH = 16'h4321;
	localparam logic [15:0] SEED_MASK_INV = 16'habcd;

	// Multiply-mode constants
	localparam logic [WORD_W-1:0] MUL_A = 32'h35ce9581;
	localparam logic [WORD_W-1:0] ADD_A = 32'h07afcc37;
	localparam logic [WORD_W-1:0] MUL_B = 32'h4c3a1353;
	localparam logic [WORD_W-1:0] ADD_B = 32'h16ef783f;

	typedef struct packed {
		logic        command;
		logic [31:0] seed;
		logic [7:0]  data_in;
		logic        last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
	} out_item_t;

	// Steps of the multiply-mode key advance
	typedef enum logic [2:0] {
		MS_SQ_LOW    = 3'd0,
		MS_SCALE_A   = 3'd1,
		MS_MUL_K1    = 3'd2,
		MS_HIGH_DONE = 3'd3,
		MS_SQ_HIGH   = 3'd4,
		MS_SCALE_B   = 3'd5,
		MS_LOW_DONE  = 3'd6
	} mul_step_t;

	typedef struct packed {
		logic      load_seed;
		logic      encrypt;
		logic      advance_simple;
		logic      mul_en;
		mul_step_t step;
	} dp_cmd_t;

	typedef struct packed {
		logic mode_mul;
	} dp_status_t;

endpackage

// ===== src/lsc_ctrl.sv =====
// Controller for the login stream cipher: request handshake and multiply sequence.
module lsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 command,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lsc_pkg::dp_status_t  status,
	output lsc_pkg::dp_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_MUL  = 2'b10
	} state_t;

	state_t             state_q;
	lsc_pkg::mul_step_t step_q;
	logic               out_valid_q;
	logic               accept;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load_seed = accept && (command == lsc_pkg::CMD_LOAD);
		cmd.encrypt = accept && (command == lsc_pkg::CMD_ENCRYPT);
		cmd.advance_simple = cmd.encrypt && !status.mode_mul;
		cmd.mul_en = (state_q == ST_MUL);
		cmd.step = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= lsc_pkg::MS_SQ_LOW;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.encrypt) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.encrypt && status.mode_mul) begin
						state_q <= ST_MUL;
						step_q <= lsc_pkg::MS_SQ_LOW;
					end
				end
				ST_MUL: begin
					if (step_q == lsc_pkg::MS_LOW_DONE) begin
						state_q <= ST_IDLE;
					end else begin
						step_q <= lsc_pkg::mul_step_t'(step_q + 3'd1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/lsc_datapath.sv =====
// Datapath for the login stream cipher: registers, key words, multiplier and output.
module lsc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [lsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lsc_pkg::WORD_W-1:0]          cfg_data,
	input  lsc_pkg::in_item_t                   in_data,
	input  lsc_pkg::dp_cmd_t                    cmd,
	output lsc_pkg::dp_status_t                 status,
	output lsc_pkg::out_item_t                  out_data
);

	logic [31:0] key_k1_q;
	logic [31:0] key_k2_q;
	logic [31:0] key_k3_q;
	logic [15:0] seed_key_q;
	logic [1:0]  cipher_mode_q;

	logic [31:0] w0_q;
	logic [31:0] w1_q;
	logic [31:0] prod_q;
	logic [31:0] acc_q;
	lsc_pkg::out_item_t out_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_lo;
	logic [31:0] sum;
	logic [4:0]  w0_sq_n;
	logic [4:0]  w1_sq_n;
	logic [4:0]  cnt_hi_n;
	logic [4:0]  cnt_lo_n;
	logic [31:0] shr_k1;
	logic [31:0] shr_k2;
	logic [31:0] seed_w0;
	logic [31:0] seed_w1;
	logic [31:0] simple_w0;
	logic [31:0] simple_w1;
	logic [31:0] cur_t;

	assign status.mode_mul = (cipher_mode_q == lsc_pkg::MODE_MUL);
	assign out_data = out_q;

	// Seed load
	assign seed_w0 = {~in_data.seed[15:0] ^ seed_key_q,
		in_data.seed[15:0] ^ lsc_pkg::SEED_MASK_LOW};
	assign seed_w1 = {~in_data.seed[31:16] ^ lsc_pkg::SEED_MASK_INV,
		in_data.seed[31:16] ^ lsc_pkg::SEED_MASK_HIGH};

	// Rotate-and-xor advance for the old and current schemes
	assign cur_t = ({w0_q[0], w1_q[31:1]} ^ key_k1_q) >> 1;
	always_comb begin
		if (cipher_mode_q == lsc_pkg::MODE_OLD) begin
			simple_w0 = {w1_q[0], w0_q[31:1]} ^ key_k2_q;
			simple_w1 = {w0_q[0], w1_q[31:1]} ^ key_k1_q;
		end else begin
			simple_w0 = {w1_q[0], w0_q[31:1]} ^ key_k3_q;
			simple_w1 = {w0_q[0] | cur_t[31], cur_t[30:0]} ^ key_k2_q;
		end
	end

	// Shift counts need only the low five bits of the squares
	assign w1_sq_n = w1_q[4:0] * w1_q[4:0];
	assign w0_sq_n = w0_q[4:0] * w0_q[4:0];
	assign cnt_hi_n = w1_sq_n * 5'd5;
	assign cnt_lo_n = w0_sq_n * 5'd3;
	assign shr_k1 = key_k1_q >> cnt_hi_n;
	assign shr_k2 = key_k2_q >> cnt_lo_n;

	// Shared multiplier operands
	always_comb begin
		unique case (cmd.step)
			lsc_pkg::MS_SQ_LOW: begin
				mul_a = w0_q;
				mul_b = w0_q;
			end
			lsc_pkg::MS_SCALE_A: begin
				mul_a = prod_q;
				mul_b = lsc_pkg::MUL_A;
			end
			lsc_pkg::MS_MUL_K1: begin
				mul_a = w1_q;
				mul_b = key_k1_q;
			end
			lsc_pkg::MS_HIGH_DONE: begin
				mul_a = w0_q;
				mul_b = key_k2_q;
			end
			lsc_pkg::MS_SQ_HIGH: begin
				mul_a = w1_q;
				mul_b = w1_q;
			end
			lsc_pkg::MS_SCALE_B: begin
				mul_a = prod_q;
				mul_b = lsc_pkg::MUL_B;
			end
			default: begin
				mul_a = prod_q;
				mul_b = lsc_pkg::MUL_B;
			end
		endcase
	end

	assign mul_lo = mul_a * mul_b;
	assign sum = acc_q + prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_lo;
			unique case (cmd.step)
				lsc_pkg::MS_SQ_LOW:    acc_q <= shr_k1 + lsc_pkg::ADD_A;
				lsc_pkg::MS_MUL_K1:    acc_q <= sum;
				lsc_pkg::MS_HIGH_DONE: acc_q <= shr_k2 + lsc_pkg::ADD_B;
				lsc_pkg::MS_SQ_HIGH:   acc_q <= sum;
				default:               acc_q <= acc_q;
			endcase
		end
		if (cmd.encrypt) begin
			out_q.data_out <= in_data.data_in ^ w0_q[7:0];
			out_q.last_out <= in_data.last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_k1_q <= '0;
			key_k2_q <= '0;
			key_k3_q <= '0;
			seed_key_q <= '0;
			cipher_mode_q <= lsc_pkg::MODE_CURRENT;
		end else if (cfg_en) begin
			unique case (cfg_index)
				lsc_pkg::REG_KEY_K1:      key_k1_q <= cfg_data;
				lsc_pkg::REG_KEY_K2:      key_k2_q <= cfg_data;
				lsc_pkg::REG_KEY_K3:      key_k3_q <= cfg_data;
				lsc_pkg::REG_SEED_KEY:    seed_key_q <= cfg_data[15:0];
				lsc_pkg::REG_CIPHER_MODE: cipher_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
		end else if (cmd.load_seed) begin
			w0_q <= seed_w0;
			w1_q <= seed_w1;
		end else if (cmd.advance_simple) begin
			w0_q <= simple_w0;
			w1_q <= simple_w1;
		end else if (cmd.mul_en && (cmd.step == lsc_pkg::MS_HIGH_DONE)) begin
			w1_q <= sum;
		end else if (cmd.mul_en && (cmd.step == lsc_pkg::MS_LOW_DONE)) begin
			w0_q <= sum;
		end
	end

endmodule

// ===== src/login_stream_cipher_top.sv =====
// Top level of the login stream cipher: controller, datapath and port wiring.
// A ciphertext byte is offered in the cycle after its request is taken.
// Seed loads and old/current-mode bytes are taken back to back unless the
// output stalls; a multiply-mode byte holds off new requests while its seven
// steps run through one shared 32x32 multiplier. Reset (arst_n low, asynchronous)
// clears the key words and all configuration registers to zero and empties the output register.
module login_stream_cipher_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lsc_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lsc_pkg::out_item_t              out_data,
	input  logic                            cfg_en,
	input  logic [lsc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lsc_pkg::WORD_W-1:0]      cfg_data
);

	// Commands from the controller, status back from the datapath
	lsc_pkg::dp_cmd_t    cmd;
	lsc_pkg::dp_status_t status;

	// Controller: take a request when idle and the output register can be
	// refilled, then run the multiply sequence where the mode calls for it.
	lsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (in_data.command),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: hold the configuration and key words, encrypt the byte with
	// the key before it advances, and advance the key.
	lsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

// ===== src/lsc_checker.sv =====
// Port-level assertions for the login stream cipher, bound to the top level.
`include "login_stream_cipher_top_assert.svh"

module lsc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input lsc_pkg::in_item_t               in_data,
	input logic                            out_valid,
	input logic                            out_ready,
	input lsc_pkg::out_item_t              out_data
);

	`LSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`LSC_ASSERT_NEXT(a_encrypt_gives_result, in_valid && in_ready && (in_data.command == lsc_pkg::CMD_ENCRYPT), out_valid)
	`LSC_ASSERT_NEXT(a_load_gives_none, in_valid && in_ready && (in_data.command == lsc_pkg::CMD_LOAD) && !out_valid, !out_valid)
	`LSC_ASSERT_NOW(a_ready_needs_room, in_ready, !out_valid || out_ready)

endmodule

bind login_stream_cipher_top lsc_checker u_lsc_checker (.*);
